>>> rtl/swm_pkg.sv
// Shared constants, types and neighbor-link structs for the sliding window median.
// Depends on nothing; every other file of the block but swm_ram takes it in.
`default_nettype none

package swm_pkg;

    // Deepest window the cell row holds
    localparam int WINDOW_MAX = 64;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;
    localparam int FILL_W   = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // Tap collection tree: leaves per group, groups in the first stage
    localparam int LEAF_N  = 8;
    localparam int GROUP_N = (WINDOW_MAX + LEAF_N - 1) / LEAF_N;

    localparam logic [CFG_W-1:0] WSIZE_RESET = CFG_W'(3);

    // Flipping the sign bit makes unsigned order match signed order
    localparam logic [SAMPLE_W-1:0] SIGN_BIAS = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SAMPLE_W-1:0] t_val;
    typedef logic        [FILL_W-1:0]   t_fill;
    typedef logic        [PTR_W-1:0]    t_ptr;
    typedef logic        [CFG_W-1:0]    t_cfg;

    // Handed from a cell to the cell below it
    typedef struct packed {
        t_val val;    // held value
        logic valid;  // cell holds a window entry for this step
        logic g;      // held value is above the new sample (or empty)
    } t_cell_up;

    // Handed from a cell to the cell above it
    typedef struct packed {
        t_val a;      // value after the oldest entry is taken out
        logic ga;     // that value is above the new sample
        logic valid;  // cell holds a window entry for this step
    } t_cell_dn;

endpackage

`default_nettype wire

>>> rtl/swm_in_if.sv
// Input channel of the sliding window median: valid/ready plus one sample item.
// Depends on swm_pkg for the payload types.
`default_nettype none

interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_sample sample;
    logic             restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/swm_out_if.sv
// Output channel of the sliding window median: valid/ready plus one median item.
// Depends on swm_pkg for the payload type.
`default_nettype none

interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_sample median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

>>> rtl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency; used for the sample history ring.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

>>> rtl/swm_cell.sv
// One slot of the sorted window row: holds a value and its valid flag and,
// on each item, takes out the oldest entry and inserts the new sample using
// only its two neighbors. Depends on swm_pkg.
`default_nettype none

module swm_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,     // item accepted this cycle
    input  wire logic              i_clear,    // window emptied by a size write
    input  wire logic              i_restart,  // item empties the window first
    input  wire logic              i_full,     // oldest entry leaves this step
    input  wire swm_pkg::t_val     i_v,        // new sample, biased
    input  wire swm_pkg::t_val     i_o,        // oldest sample, biased
    input  wire swm_pkg::t_cell_dn i_lo,       // from the cell below
    input  wire swm_pkg::t_cell_up i_hi,       // from the cell above
    output swm_pkg::t_cell_dn      o_dn,       // to the cell above
    output swm_pkg::t_cell_up      o_up        // to the cell below
);
    import swm_pkg::*;

    t_val r_val;
    t_val n_val;
    logic r_valid;
    logic n_valid;

    logic valid_e;
    logic g;
    logic e;
    t_val a;
    logic ga;

    // Local compares and the shift/insert choice
    always_comb begin
        valid_e = r_valid && !i_restart;
        g       = !valid_e || (r_val > i_v);
        // at or above the entry that leaves: take the upper neighbor's value
        e       = i_full && valid_e && (r_val >= i_o);
        a       = e ? i_hi.val : r_val;
        ga      = e ? i_hi.g   : g;

        if (!ga) begin
            n_val = a;
        end else if (i_lo.ga) begin
            n_val = i_lo.a;
        end else begin
            n_val = i_v;
        end
        // a full window keeps its count; otherwise it grows by one
        n_valid = i_full ? valid_e : (valid_e || i_lo.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_val <= n_val;
        end
    end

    assign o_dn = '{a: a, ga: ga, valid: valid_e};
    assign o_up = '{val: r_val, valid: valid_e, g: g};

endmodule

`default_nettype wire

>>> rtl/sliding_window_median_top.sv
// Top level of the sliding window median: control, history ring, cell row,
// median tap tree and output register. Depends on swm_pkg, swm_in_if,
// swm_out_if, swm_ram and swm_cell.
`default_nettype none

// Running lower median over the last window_size signed samples (1..64; 0 acts
// as 1, larger values as 64). The block takes one sample per clock cycle unless
// o_med.ready stalls the output: a row of 64 cells keeps the window sorted and,
// in the cycle a sample is accepted, drops the oldest entry and inserts the new
// one, each cell looking only at its two neighbors. The oldest sample comes from
// a history RAM read one item ahead. A median passes the cell row, the first tap
// tree stage and the output register, and leaves only once window_size samples
// have arrived since reset, a restart item or a write of window_size; each later
// sample yields one median. A write of window_size empties the window; the user
// must issue it only while the block is idle, and the block does not enforce
// this. There is no clearing pass after reset.
module sliding_window_median_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    swm_in_if.sink                     i_smp,
    swm_out_if.source                  o_med,
    input  wire logic                  i_cfg_we,
    input  wire logic [swm_pkg::CFG_W-1:0] i_cfg_data
);
    import swm_pkg::*;

    // Control registers
    t_cfg  r_wsize;
    t_fill r_fill;
    t_fill n_fill;
    t_ptr  r_ptr;
    t_ptr  n_ptr;
    logic  r_byp;
    t_val  r_byp_data;
    logic  r_p1;
    logic  n_p1;
    logic  r_p2;
    logic  r_out_v;
    t_val  r_part [GROUP_N];
    t_sample r_out;

    t_fill w_eff;
    t_ptr  mid;
    logic  acc;
    logic  adv_out;
    logic  adv2;
    logic  adv1;
    t_val  v;
    t_val  o;
    t_val  ram_q;
    t_fill base_fill;
    t_ptr  base_ptr;
    t_fill fill_inc;
    t_fill ptr_inc;
    logic  full;
    logic  result;
    t_val  part [GROUP_N];
    t_val  tap;

    t_cell_up c_up [WINDOW_MAX];
    t_cell_dn c_dn [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] c_valid;

    // Effective window length and the lower median index
    always_comb begin
        if (r_wsize == '0) begin
            w_eff = FILL_W'(1);
        end else if (int'(r_wsize) > WINDOW_MAX) begin
            w_eff = FILL_W'(WINDOW_MAX);
        end else begin
            w_eff = FILL_W'(r_wsize);
        end
        mid = PTR_W'((w_eff - FILL_W'(1)) >> 1);
    end

    // Pipeline advance: cell row -> tap stage -> output register
    assign adv_out     = !r_out_v || o_med.ready;
    assign adv2        = !r_p2 || adv_out;
    assign adv1        = !r_p1 || adv2;
    assign i_smp.ready = adv1;
    assign acc         = i_smp.valid && adv1;

    // Fill count, ring pointer and result decision for the accepted item
    always_comb begin
        v         = t_val'(i_smp.sample) ^ SIGN_BIAS;
        base_fill = i_smp.restart ? '0 : r_fill;
        base_ptr  = i_smp.restart ? '0 : r_ptr;
        full      = (base_fill == w_eff);
        fill_inc  = FILL_W'(base_fill + FILL_W'(1));
        ptr_inc   = FILL_W'(FILL_W'(base_ptr) + FILL_W'(1));
        result    = full || (fill_inc == w_eff);

        n_fill = r_fill;
        n_ptr  = r_ptr;
        if (i_cfg_we) begin
            n_fill = '0;
            n_ptr  = '0;
        end else if (acc) begin
            n_fill = full ? base_fill : fill_inc;
            n_ptr  = (ptr_inc >= w_eff) ? '0 : PTR_W'(ptr_inc);
        end
        n_p1 = acc ? result : (r_p1 && !adv2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WSIZE_RESET;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_byp   <= 1'b0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wsize <= i_cfg_data;
            end
            r_fill <= n_fill;
            r_ptr  <= n_ptr;
            r_byp  <= acc && (base_ptr == n_ptr);
            r_p1   <= n_p1;
            if (adv2) begin
                r_p2 <= r_p1;
            end
            if (adv_out) begin
                r_out_v <= r_p2;
            end
        end
    end

    // History ring; the read runs one item ahead, with a bypass when the
    // slot just written is the next one to leave
    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (base_ptr),
        .i_wdata (v),
        .i_raddr (n_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_byp_data <= v;
    end

    assign o = r_byp ? r_byp_data : ram_q;

    // Sorted cell row
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        t_cell_dn lo;
        t_cell_up hi;

        if (gi == 0) begin : g_lo_edge
            assign lo = '{a: '0, ga: 1'b0, valid: 1'b1};
        end else begin : g_lo_link
            assign lo = c_dn[gi-1];
        end

        if (gi == WINDOW_MAX - 1) begin : g_hi_edge
            assign hi = '{val: '0, valid: 1'b0, g: 1'b1};
        end else begin : g_hi_link
            assign hi = c_up[gi+1];
        end

        swm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (acc),
            .i_clear   (i_cfg_we),
            .i_restart (i_smp.restart),
            .i_full    (full),
            .i_v       (v),
            .i_o       (o),
            .i_lo      (lo),
            .i_hi      (hi),
            .o_dn      (c_dn[gi]),
            .o_up      (c_up[gi])
        );

        assign c_valid[gi] = c_up[gi].valid;
    end

    // Median tap, first stage: one OR group per LEAF_N cells
    always_comb begin
        for (int k = 0; k < GROUP_N; k++) begin
            part[k] = '0;
            for (int j = 0; j < LEAF_N; j++) begin
                if ((k * LEAF_N + j) < WINDOW_MAX) begin
                    if (mid == PTR_W'(k * LEAF_N + j)) begin
                        part[k] = part[k] | c_up[k * LEAF_N + j].val;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_p1) begin
            r_part <= part;
        end
    end

    // Median tap, second stage into the output register
    always_comb begin
        tap = '0;
        for (int k = 0; k < GROUP_N; k++) begin
            tap = tap | r_part[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_p2) begin
            r_out <= t_sample'(tap ^ SIGN_BIAS);
        end
    end

    assign o_med.valid  = r_out_v;
    assign o_med.median = r_out;

`ifndef SYNTH
    // Fill count never passes the window length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count above window length");

    // Ring pointer stays inside the window
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_fill'(r_ptr) < w_eff)
        else $error("history pointer outside window");

    // Occupied cells match the fill count
    a_cells_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.restart |-> ($countones(c_valid) == int'(r_fill)))
        else $error("cell occupancy differs from fill count");

    // A size write empties the window
    a_cfg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_fill == '0))
        else $error("window not emptied by size write");

    // An item that completes a window always enters the tap pipeline
    a_result_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && result && !i_cfg_we) |=> r_p1)
        else $error("result lost after cell row");
`endif

endmodule

`default_nettype wire
